// File: design/asep_pkg.sv
// Shared types, byte codes, parser mode and action codes for the escape parser.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package asep_pkg;

    localparam int MAX_DIGITS_DEF = 2;

    localparam logic [7:0] BYTE_EOT     = 8'h04;
    localparam logic [7:0] BYTE_LF      = 8'h0a;
    localparam logic [7:0] BYTE_ESC     = 8'h1b;
    localparam logic [7:0] BYTE_CARET   = 8'h5e;
    localparam logic [7:0] BYTE_LBRACK  = 8'h5b;
    localparam logic [7:0] BYTE_SGR_END = 8'h6d;
    localparam logic [7:0] BYTE_LOW_D   = 8'h64;
    localparam logic [7:0] BYTE_UP_D    = 8'h44;
    localparam logic [7:0] DIGIT_HI     = 8'h30;
    localparam logic [7:0] HI_MASK      = 8'hf0;
    localparam logic [7:0] LO_MASK      = 8'h0f;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_CARET  = 2'd1;
    localparam logic [1:0] MODE_ESC    = 2'd2;
    localparam logic [1:0] MODE_CSI    = 2'd3;

    localparam logic [1:0] ACT_TYPE    = 2'd0;
    localparam logic [1:0] ACT_NEWLINE = 2'd1;
    localparam logic [1:0] ACT_SPACING = 2'd2;
    localparam logic [1:0] ACT_EOT     = 2'd3;

    localparam logic [1:0] SPACING_SINGLE = 2'd0;
    localparam logic [1:0] SPACING_ONE_HALF = 2'd1;
    localparam logic [1:0] SPACING_DOUBLE = 2'd2;
    localparam logic [1:0] SPACING_TRIPLE = 2'd3;

    localparam int SGR_RESET      = 0;
    localparam int SGR_BOLD       = 1;
    localparam int SGR_UNDERLINE  = 4;
    localparam int SGR_SPACE_1    = 10;
    localparam int SGR_SPACE_15   = 11;
    localparam int SGR_SPACE_2    = 12;
    localparam int SGR_SPACE_3    = 13;
    localparam int SGR_BOLD_OFF   = 22;
    localparam int SGR_ULINE_OFF  = 24;

    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_CARET_CTRL = 3'd0;

    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic accept;
        logic load;
        logic sel_tail;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic plan_flush;
        logic plan_tail;
        logic tail_v;
        logic flush_last;
        logic slot_free;
    } t_sts;

    function automatic logic is_dec(input logic [7:0] b);
        logic hi_ok;
        hi_ok = (b & HI_MASK) == DIGIT_HI;
        return hi_ok && ((b & LO_MASK) <= 8'd9);
    endfunction

endpackage

// File: design/asep_ctrl.sv
// Controller state machine of the escape parser: input handshake and result sequencing.
// Depends on asep_pkg; drives the datapath through t_cmd and reads t_sts.
`timescale 1ns / 1ps

module asep_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  asep_pkg::t_sts i_sts,
    output asep_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FLUSH = 3'b010,
        S_TAIL  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.sel_tail = 1'b0;
        o_cmd.last     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.plan_flush) begin
                        n_state = S_FLUSH;
                    end else if (i_sts.plan_tail) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_FLUSH: begin
                if (i_sts.slot_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.last = i_sts.flush_last && !i_sts.tail_v;
                    if (i_sts.flush_last) begin
                        n_state = i_sts.tail_v ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL: begin
                if (i_sts.slot_free) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.sel_tail = 1'b1;
                    o_cmd.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/asep_datapath.sv
// Datapath of the escape parser: parse state, style, held bytes and the output register.
// Depends on asep_pkg; commanded by asep_ctrl.
`timescale 1ns / 1ps

module asep_datapath #(
    parameter int MAX_DIGITS = asep_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_caret,
    input  logic [7:0]                      i_byte,
    input  asep_pkg::t_cmd                  i_cmd,
    output asep_pkg::t_sts                  o_sts,
    output logic                            o_m_tvalid,
    output logic [asep_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast,
    input  logic                            i_m_tready
);

    localparam int HOLD_DEPTH = 3 + MAX_DIGITS;
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W      = $clog2(HOLD_DEPTH);
    localparam int DIG_W      = $clog2(MAX_DIGITS + 1);
    localparam int VAL_W      = $clog2(10 ** MAX_DIGITS);

    logic [1:0]       r_mode,    n_mode;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic [DIG_W-1:0] r_digits,  n_digits;
    logic [VAL_W-1:0] r_val,     n_val;
    logic             r_bold,    n_bold;
    logic             r_uline,   n_uline;
    logic [1:0]       r_spacing, n_spacing;
    logic [7:0]       r_held [HOLD_DEPTH];

    logic [CNT_W-1:0] r_flush_n, n_flush_n;
    logic             r_tail_v,  n_tail_v;
    logic [1:0]       r_tail_act, n_tail_act;
    logic [7:0]       r_tail_char, n_tail_char;
    logic [IDX_W-1:0] r_rd_idx;

    logic                            r_out_valid;
    logic [asep_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                            r_out_last;

    logic       w_hold;
    logic       w_dec;
    logic       w_sgr_ok;
    logic [1:0] w_act;
    logic [7:0] w_char;

    assign w_dec = asep_pkg::is_dec(i_byte);

    always_comb begin
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_digits    = r_digits;
        n_val       = r_val;
        n_bold      = r_bold;
        n_uline     = r_uline;
        n_spacing   = r_spacing;
        n_flush_n   = '0;
        n_tail_v    = 1'b0;
        n_tail_act  = asep_pkg::ACT_TYPE;
        n_tail_char = i_byte;
        w_hold      = 1'b0;
        w_sgr_ok    = 1'b0;
        case (r_mode)
            asep_pkg::MODE_NORMAL: begin
                if (i_cfg_caret && (i_byte == asep_pkg::BYTE_CARET)) begin
                    w_hold = 1'b1;
                    n_mode = asep_pkg::MODE_CARET;
                end else if (i_byte == asep_pkg::BYTE_EOT) begin
                    n_cnt       = '0;
                    n_digits    = '0;
                    n_bold      = 1'b0;
                    n_uline     = 1'b0;
                    n_spacing   = asep_pkg::SPACING_SINGLE;
                    n_tail_v    = 1'b1;
                    n_tail_act  = asep_pkg::ACT_EOT;
                    n_tail_char = 8'h00;
                end else if (i_byte == asep_pkg::BYTE_LF) begin
                    n_tail_v    = 1'b1;
                    n_tail_act  = asep_pkg::ACT_NEWLINE;
                    n_tail_char = 8'h00;
                end else if (i_byte == asep_pkg::BYTE_ESC) begin
                    w_hold = 1'b1;
                    n_mode = asep_pkg::MODE_ESC;
                end else begin
                    n_tail_v = 1'b1;
                end
            end
            asep_pkg::MODE_CARET: begin
                if ((i_byte == asep_pkg::BYTE_LOW_D) || (i_byte == asep_pkg::BYTE_UP_D)) begin
                    n_mode      = asep_pkg::MODE_NORMAL;
                    n_cnt       = '0;
                    n_digits    = '0;
                    n_bold      = 1'b0;
                    n_uline     = 1'b0;
                    n_spacing   = asep_pkg::SPACING_SINGLE;
                    n_tail_v    = 1'b1;
                    n_tail_act  = asep_pkg::ACT_EOT;
                    n_tail_char = 8'h00;
                end else if (i_byte == asep_pkg::BYTE_LBRACK) begin
                    w_hold = 1'b1;
                    n_mode = asep_pkg::MODE_ESC;
                end else begin
                    n_flush_n = r_cnt;
                    n_tail_v  = 1'b1;
                end
            end
            asep_pkg::MODE_ESC: begin
                if (i_byte == asep_pkg::BYTE_LBRACK) begin
                    w_hold = 1'b1;
                    n_mode = asep_pkg::MODE_CSI;
                end else begin
                    n_flush_n = r_cnt;
                    n_tail_v  = 1'b1;
                end
            end
            asep_pkg::MODE_CSI: begin
                if (i_byte == asep_pkg::BYTE_SGR_END) begin
                    if (r_digits != '0) begin
                        w_sgr_ok = 1'b1;
                        case (32'(r_val))
                            asep_pkg::SGR_RESET: begin
                                n_bold    = 1'b0;
                                n_uline   = 1'b0;
                                n_spacing = asep_pkg::SPACING_SINGLE;
                            end
                            asep_pkg::SGR_BOLD:      n_bold    = 1'b1;
                            asep_pkg::SGR_UNDERLINE: n_uline   = 1'b1;
                            asep_pkg::SGR_SPACE_1:   n_spacing = asep_pkg::SPACING_SINGLE;
                            asep_pkg::SGR_SPACE_15:  n_spacing = asep_pkg::SPACING_ONE_HALF;
                            asep_pkg::SGR_SPACE_2:   n_spacing = asep_pkg::SPACING_DOUBLE;
                            asep_pkg::SGR_SPACE_3:   n_spacing = asep_pkg::SPACING_TRIPLE;
                            asep_pkg::SGR_BOLD_OFF:  n_bold    = 1'b0;
                            asep_pkg::SGR_ULINE_OFF: n_uline   = 1'b0;
                            default:                 w_sgr_ok  = 1'b0;
                        endcase
                    end
                    if (w_sgr_ok) begin
                        n_tail_v    = 1'b1;
                        n_tail_act  = asep_pkg::ACT_SPACING;
                        n_tail_char = 8'h00;
                    end else begin
                        n_flush_n = r_cnt;
                    end
                end else if (w_dec) begin
                    if (r_digits == DIG_W'(MAX_DIGITS)) begin
                        n_flush_n = r_cnt;
                        n_tail_v  = 1'b1;
                    end else begin
                        w_hold   = 1'b1;
                        n_digits = r_digits + DIG_W'(1);
                        n_val    = ((r_digits == '0) ? VAL_W'(0) : VAL_W'(r_val * VAL_W'(10)))
                                   + VAL_W'(i_byte[3:0]);
                    end
                end else begin
                    n_flush_n = r_cnt;
                    n_tail_v  = 1'b1;
                end
            end
            default: begin
                n_mode = asep_pkg::MODE_NORMAL;
            end
        endcase
        if ((n_flush_n != '0) || n_tail_v) begin
            n_mode   = asep_pkg::MODE_NORMAL;
            n_cnt    = '0;
            n_digits = '0;
        end
        if (w_hold && (r_cnt < CNT_W'(HOLD_DEPTH))) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= asep_pkg::MODE_NORMAL;
            r_cnt     <= '0;
            r_digits  <= '0;
            r_bold    <= 1'b0;
            r_uline   <= 1'b0;
            r_spacing <= asep_pkg::SPACING_SINGLE;
            r_flush_n <= '0;
            r_tail_v  <= 1'b0;
            r_rd_idx  <= '0;
        end else if (i_cmd.accept) begin
            r_mode    <= n_mode;
            r_cnt     <= n_cnt;
            r_digits  <= n_digits;
            r_bold    <= n_bold;
            r_uline   <= n_uline;
            r_spacing <= n_spacing;
            r_flush_n <= n_flush_n;
            r_tail_v  <= n_tail_v;
            r_rd_idx  <= '0;
        end else if (i_cmd.load && !i_cmd.sel_tail) begin
            r_rd_idx <= r_rd_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val       <= n_val;
            r_tail_act  <= n_tail_act;
            r_tail_char <= n_tail_char;
            if (w_hold && (r_cnt < CNT_W'(HOLD_DEPTH))) begin
                r_held[r_cnt[IDX_W-1:0]] <= i_byte;
            end
        end
    end

    always_comb begin
        if (i_cmd.sel_tail) begin
            w_act  = r_tail_act;
            w_char = r_tail_char;
        end else begin
            w_act  = asep_pkg::ACT_TYPE;
            w_char = r_held[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data <= {r_mode, r_spacing, r_uline, r_bold, w_char, w_act};
            r_out_last <= i_cmd.last;
        end
    end

    assign o_sts.plan_flush = (n_flush_n != '0);
    assign o_sts.plan_tail  = n_tail_v;
    assign o_sts.tail_v     = r_tail_v;
    assign o_sts.flush_last = ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_flush_n);
    assign o_sts.slot_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// File: design/ansi_style_escape_parser_unit.sv
// Top level of the escape parser: stream ports, APB register, controller and datapath.
// Depends on asep_pkg, asep_ctrl and asep_datapath.
//
//   Channel  Dir  Signals                          Transaction
//   s_axis   in   tvalid tready tdata[7:0]         one text byte
//   m_axis   out  tvalid tready tdata[15:0] tlast  one typing action
//   apb      in   psel penable pwrite paddr pwdata register 0 caret control
//
// A byte is accepted and then causes from none up to MAX_DIGITS + 4 results; the result
// sequencer hands out one result a cycle while m_axis does not stall.
// The next byte is accepted once the last result of the previous one is loaded
// into the output register, even while that result still waits to be taken.
// A stalled m_axis holds the sequencer; reset is synchronous and active low.
`timescale 1ns / 1ps

module ansi_style_escape_parser_unit #(
    parameter int MAX_DIGITS = asep_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // in_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // action[1:0], char_code[9:2], bold[10], underline[11], line_spacing[13:12],
    // parser_mode[15:14]
    output logic [asep_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [asep_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic           r_caret_ctrl;
    logic           w_reg_sel;
    asep_pkg::t_cmd w_cmd;
    asep_pkg::t_sts w_sts;

    assign pready = 1'b1;

    // Registers are word aligned, so the byte lane bits of the address are ignored.
    assign w_reg_sel = (paddr[asep_pkg::APB_ADDR_W-1:2]
                        == asep_pkg::ADDR_CARET_CTRL[asep_pkg::APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caret_ctrl <= 1'b0;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_caret_ctrl <= pwdata[0];
        end
    end

    assign prdata = w_reg_sel ? {31'd0, r_caret_ctrl} : 32'd0;

    asep_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    asep_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_caret (r_caret_ctrl),
        .i_byte      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast),
        .i_m_tready  (m_axis_tready)
    );

endmodule

// File: dv/typing_action_checker.sv
// Scoreboard for the escape parser: watches the byte stream, the action stream and the
// APB register writes, predicts every typing action and compares it field by field.
// Depends on asep_pkg.
`timescale 1ns / 1ps

module typing_action_checker #(
    parameter int MAX_DIGITS = asep_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [7:0]                      i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [asep_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                            i_m_tlast,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [asep_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [31:0]                     i_pwdata,
    input  logic                            i_pready,
    output int                              o_mismatches,
    output int                              o_pending
);

    localparam int HOLD_DEPTH = 3 + MAX_DIGITS;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic       bold;
        logic       underline;
        logic [1:0] spacing;
        logic [1:0] mode;
        logic       last;
    } t_typing;

    t_typing    typing_q[$];
    t_typing    byte_actions[$];

    logic       caret_ctrl;
    logic [1:0] cur_mode;
    logic [7:0] held [HOLD_DEPTH];
    int         held_n;
    logic       bold_q;
    logic       uline_q;
    logic [1:0] spacing_q;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic int digit_count();
        int i;
        int n;
        n = 0;
        for (i = 0; i < held_n; i++)
            if (is_digit(held[i]))
                n++;
        return n;
    endfunction

    function automatic t_typing styled(input logic [1:0] act, input logic [7:0] ch);
        t_typing t;
        t.action    = act;
        t.char_code = (act == asep_pkg::ACT_TYPE) ? ch : 8'h00;
        t.bold      = bold_q;
        t.underline = uline_q;
        t.spacing   = spacing_q;
        t.mode      = cur_mode;
        t.last      = 1'b0;
        return t;
    endfunction

    task automatic push_act(input logic [1:0] act, input logic [7:0] ch);
        byte_actions.push_back(styled(act, ch));
    endtask

    task automatic hold_byte(input logic [7:0] b);
        if (held_n < HOLD_DEPTH) begin
            held[held_n] = b;
            held_n++;
        end
    endtask

    task automatic flush_held(input logic with_cur, input logic [7:0] b);
        int i;
        int cnt;
        cnt      = held_n;
        cur_mode = asep_pkg::MODE_NORMAL;
        held_n   = 0;
        for (i = 0; i < cnt; i++)
            push_act(asep_pkg::ACT_TYPE, held[i]);
        if (with_cur)
            push_act(asep_pkg::ACT_TYPE, b);
    endtask

    task automatic end_text();
        held_n    = 0;
        bold_q    = 1'b0;
        uline_q   = 1'b0;
        spacing_q = asep_pkg::SPACING_SINGLE;
        cur_mode  = asep_pkg::MODE_NORMAL;
        push_act(asep_pkg::ACT_EOT, 8'h00);
    endtask

    task automatic apply_code(output logic ok);
        int i;
        int value;
        value = 0;
        ok    = 1'b1;
        for (i = 0; i < held_n; i++)
            if (is_digit(held[i]))
                value = value * 10 + int'(held[i] - asep_pkg::DIGIT_HI);
        if (digit_count() == 0) begin
            ok = 1'b0;
        end else begin
            case (value)
                asep_pkg::SGR_RESET: begin
                    bold_q    = 1'b0;
                    uline_q   = 1'b0;
                    spacing_q = asep_pkg::SPACING_SINGLE;
                end
                asep_pkg::SGR_BOLD:      bold_q    = 1'b1;
                asep_pkg::SGR_UNDERLINE: uline_q   = 1'b1;
                asep_pkg::SGR_SPACE_1:   spacing_q = asep_pkg::SPACING_SINGLE;
                asep_pkg::SGR_SPACE_15:  spacing_q = asep_pkg::SPACING_ONE_HALF;
                asep_pkg::SGR_SPACE_2:   spacing_q = asep_pkg::SPACING_DOUBLE;
                asep_pkg::SGR_SPACE_3:   spacing_q = asep_pkg::SPACING_TRIPLE;
                asep_pkg::SGR_BOLD_OFF:  bold_q    = 1'b0;
                asep_pkg::SGR_ULINE_OFF: uline_q   = 1'b0;
                default:                 ok        = 1'b0;
            endcase
        end
    endtask

    task automatic predict_typing(input logic [7:0] b);
        logic    ok;
        t_typing t;
        byte_actions.delete();
        case (cur_mode)
            asep_pkg::MODE_NORMAL: begin
                if (caret_ctrl && b == asep_pkg::BYTE_CARET) begin
                    hold_byte(b);
                    cur_mode = asep_pkg::MODE_CARET;
                end else if (b == asep_pkg::BYTE_EOT) begin
                    end_text();
                end else if (b == asep_pkg::BYTE_LF) begin
                    push_act(asep_pkg::ACT_NEWLINE, 8'h00);
                end else if (b == asep_pkg::BYTE_ESC) begin
                    hold_byte(b);
                    cur_mode = asep_pkg::MODE_ESC;
                end else begin
                    push_act(asep_pkg::ACT_TYPE, b);
                end
            end
            asep_pkg::MODE_CARET: begin
                if (b == asep_pkg::BYTE_LOW_D || b == asep_pkg::BYTE_UP_D) begin
                    end_text();
                end else if (b == asep_pkg::BYTE_LBRACK) begin
                    hold_byte(b);
                    cur_mode = asep_pkg::MODE_ESC;
                end else begin
                    flush_held(1'b1, b);
                end
            end
            asep_pkg::MODE_ESC: begin
                if (b == asep_pkg::BYTE_LBRACK) begin
                    hold_byte(b);
                    cur_mode = asep_pkg::MODE_CSI;
                end else begin
                    flush_held(1'b1, b);
                end
            end
            default: begin
                if (b == asep_pkg::BYTE_SGR_END) begin
                    apply_code(ok);
                    if (ok) begin
                        held_n   = 0;
                        cur_mode = asep_pkg::MODE_NORMAL;
                        push_act(asep_pkg::ACT_SPACING, 8'h00);
                    end else begin
                        flush_held(1'b0, 8'h00);
                    end
                end else if (is_digit(b)) begin
                    if (digit_count() + 1 > MAX_DIGITS)
                        flush_held(1'b1, b);
                    else
                        hold_byte(b);
                end else begin
                    flush_held(1'b1, b);
                end
            end
        endcase
        if (byte_actions.size() > 0) begin
            t = byte_actions.pop_back();
            t.last = 1'b1;
            byte_actions.push_back(t);
        end
        while (byte_actions.size() > 0)
            typing_q.push_back(byte_actions.pop_front());
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        o_mismatches++;
        $display("[%0t] typing action mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
    endtask

    task automatic check_result();
        t_typing got;
        t_typing want;
        got.action    = i_m_tdata[1:0];
        got.char_code = i_m_tdata[9:2];
        got.bold      = i_m_tdata[10];
        got.underline = i_m_tdata[11];
        got.spacing   = i_m_tdata[13:12];
        got.mode      = i_m_tdata[15:14];
        got.last      = i_m_tlast;
        if (typing_q.size() == 0) begin
            report_mismatch("a transaction with nothing expected", int'(i_m_tdata), 0);
        end else begin
            want = typing_q.pop_front();
            if (got.action !== want.action)
                report_mismatch("action", got.action, want.action);
            if (got.char_code !== want.char_code)
                report_mismatch("char_code", got.char_code, want.char_code);
            if (got.bold !== want.bold)
                report_mismatch("bold", got.bold, want.bold);
            if (got.underline !== want.underline)
                report_mismatch("underline", got.underline, want.underline);
            if (got.spacing !== want.spacing)
                report_mismatch("line_spacing", got.spacing, want.spacing);
            if (got.mode !== want.mode)
                report_mismatch("parser_mode", got.mode, want.mode);
            if (got.last !== want.last)
                report_mismatch("tlast", got.last, want.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            caret_ctrl   = 1'b0;
            cur_mode     = asep_pkg::MODE_NORMAL;
            held_n       = 0;
            bold_q       = 1'b0;
            uline_q      = 1'b0;
            spacing_q    = asep_pkg::SPACING_SINGLE;
            o_mismatches = 0;
            typing_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && i_s_tready)
                predict_typing(i_s_tdata);
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr[asep_pkg::APB_ADDR_W-1:2]
                   == asep_pkg::ADDR_CARET_CTRL[asep_pkg::APB_ADDR_W-1:2])
                caret_ctrl = i_pwdata[0];
        end
        o_pending = typing_q.size();
    end

endmodule

// File: dv/ansi_style_escape_parser_unit_tb.sv
// Testbench top for the escape parser: clock, reset, byte stimulus, APB writes,
// output back-pressure and the final verdict. Depends on asep_pkg, the parser top
// level and typing_action_checker.
`timescale 1ns / 1ps

module ansi_style_escape_parser_unit_tb;

    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 80;
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [asep_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [asep_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    int         mismatches;
    int         pending;
    int         quiet_cycles;
    int         sent;
    bit         tx_idle_en;
    bit         rx_idle_en;
    bit         hold_rx_req;
    logic [7:0] text_plan[$];

    ansi_style_escape_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    typing_action_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The receiver either stalls in short bursts or, on request, holds off for a long stretch.
    initial begin
        bit long_done;
        long_done     = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_rx_req && !long_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_done = 1'b1;
                m_axis_tready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic apb_write(input logic [asep_pkg::APB_ADDR_W-1:0] addr, input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {31'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic send_plan();
        while (text_plan.size() > 0)
            send_byte(text_plan.pop_front());
    endtask

    task automatic drain_actions();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly SGR sequences with random content, some of them broken, the rest noise.
    task automatic plan_random();
        int         kind;
        int         code;
        int         i;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            if ($urandom_range(0, 2) == 0) begin
                text_plan.push_back(asep_pkg::BYTE_CARET);
                text_plan.push_back(asep_pkg::BYTE_LBRACK);
            end else begin
                text_plan.push_back(asep_pkg::BYTE_ESC);
            end
            text_plan.push_back(asep_pkg::BYTE_LBRACK);
            if (kind < 4) begin
                case ($urandom_range(0, 8))
                    0:       code = asep_pkg::SGR_RESET;
                    1:       code = asep_pkg::SGR_BOLD;
                    2:       code = asep_pkg::SGR_UNDERLINE;
                    3:       code = asep_pkg::SGR_SPACE_1;
                    4:       code = asep_pkg::SGR_SPACE_15;
                    5:       code = asep_pkg::SGR_SPACE_2;
                    6:       code = asep_pkg::SGR_SPACE_3;
                    7:       code = asep_pkg::SGR_BOLD_OFF;
                    default: code = asep_pkg::SGR_ULINE_OFF;
                endcase
                if (code >= 10 || $urandom_range(0, 1) == 0)
                    text_plan.push_back(asep_pkg::DIGIT_HI + 8'(code / 10));
                text_plan.push_back(asep_pkg::DIGIT_HI + 8'(code % 10));
            end else begin
                for (i = $urandom_range(0, 3); i > 0; i--)
                    text_plan.push_back(asep_pkg::DIGIT_HI + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 7) != 0)
                text_plan.push_back(asep_pkg::BYTE_SGR_END);
            else
                text_plan.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 6) begin
            text_plan.push_back(asep_pkg::BYTE_CARET);
            case ($urandom_range(0, 3))
                0:       b = asep_pkg::BYTE_LOW_D;
                1:       b = asep_pkg::BYTE_UP_D;
                2:       b = asep_pkg::BYTE_LBRACK;
                default: b = 8'($urandom_range(0, 255));
            endcase
            text_plan.push_back(b);
        end else if (kind == 7) begin
            text_plan.push_back(asep_pkg::BYTE_ESC);
            text_plan.push_back(8'($urandom_range(0, 255)));
        end else begin
            for (i = $urandom_range(1, 4); i > 0; i--) begin
                case ($urandom_range(0, 9))
                    0:       b = asep_pkg::BYTE_LF;
                    1:       b = asep_pkg::BYTE_EOT;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                text_plan.push_back(b);
            end
        end
    endtask

    initial begin
        int phase;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = 32'h0;
        sent          = 0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        hold_rx_req   = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apb_write(asep_pkg::ADDR_CARET_CTRL, 1'b0);
        text_plan = '{8'h00, 8'hff, asep_pkg::BYTE_CARET, asep_pkg::BYTE_LF,
                      asep_pkg::BYTE_ESC, asep_pkg::BYTE_LBRACK, "1", "2", "3",
                      asep_pkg::BYTE_ESC, "x",
                      asep_pkg::BYTE_ESC, asep_pkg::BYTE_LBRACK, asep_pkg::BYTE_SGR_END,
                      asep_pkg::BYTE_EOT,
                      asep_pkg::BYTE_ESC, asep_pkg::BYTE_LBRACK};
        send_plan();
        // The control sequence stays open across the register write.
        drain_actions();
        apb_write(asep_pkg::ADDR_CARET_CTRL, 1'b1);
        text_plan = '{"1", asep_pkg::BYTE_SGR_END,
                      asep_pkg::BYTE_CARET, asep_pkg::BYTE_LOW_D,
                      asep_pkg::BYTE_CARET, asep_pkg::BYTE_LBRACK, asep_pkg::BYTE_LBRACK,
                      "0", "4", asep_pkg::BYTE_SGR_END,
                      asep_pkg::BYTE_CARET, "z"};
        send_plan();

        for (phase = 0; phase < PHASES; phase++) begin
            drain_actions();
            apb_write(asep_pkg::ADDR_CARET_CTRL, (phase % 2 == 0) ? 1'b1 : 1'b0);
            tx_idle_en = (phase < PHASES - 1);
            rx_idle_en = (phase < PHASES - 1);
            if (phase == 1)
                hold_rx_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                plan_random();
                send_plan();
            end
        end

        drain_actions();
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
